>>> hdl/virq_enable_change_mapper_macros.svh
// assertion macros for the checker file
`ifndef VIRQ_ENABLE_CHANGE_MAPPER_MACROS_SVH
`define VIRQ_ENABLE_CHANGE_MAPPER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define VIRQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("virq check failed");

// next-cycle implication, sampled on clk, off during reset
`define VIRQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("virq check failed");

`endif

>>> hdl/virq_pkg.sv
`default_nettype none

package virq_pkg;

    localparam int PIRQ_W     = 8;
    localparam int GUEST_W    = 3;
    localparam int VIRQ_W     = 7;
    localparam int WORD_W     = 32;
    localparam int BIT_W      = 5;
    localparam int WORD_IDX_W = 2;
    localparam int FUNC_W     = 2;
    localparam int KIND_W     = 3;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UPD   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FWD   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_REV   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_EN    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DIS   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UNMAP = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FWD   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REV   = 3'd4;

    typedef struct packed {
        logic [GUEST_W-1:0] guest;
        logic [VIRQ_W-1:0]  virq;
    } entry_t;

    typedef struct packed {
        logic done;
        logic hit;
    } scan_sts_t;

endpackage

`default_nettype wire

>>> hdl/virq_ram.sv
`default_nettype none

module virq_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic             re,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/virq_scan_unit.sv
`default_nettype none

module virq_scan_unit import virq_pkg::*; #(
    parameter int PHYS_IRQ_COUNT = 256,
    localparam int AW = $clog2(PHYS_IRQ_COUNT)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [GUEST_W-1:0] key_guest,
    input  wire logic [VIRQ_W-1:0]  key_virq,
    input  wire logic               ent_valid,
    input  wire entry_t             rd_entry,
    output logic      [AW-1:0]      rd_addr,
    output logic                    rd_en,
    output scan_sts_t               sts,
    output logic      [AW-1:0]      hit_idx
);

    logic          busy_reg;
    logic          pend_reg;
    logic [AW:0]   addr_reg;
    logic [AW-1:0] idx_reg;
    logic          vbit_reg;
    logic          hit;
    logic          miss;
    logic          issue;

    // compare the entry read last cycle against the key
    assign hit   = pend_reg & vbit_reg & (rd_entry.guest == key_guest)
                   & (rd_entry.virq == key_virq);
    assign miss  = busy_reg & ~pend_reg & (addr_reg == (AW+1)'(PHYS_IRQ_COUNT));
    assign issue = busy_reg & (addr_reg < (AW+1)'(PHYS_IRQ_COUNT)) & ~hit;

    assign rd_addr  = addr_reg[AW-1:0];
    assign rd_en    = issue;
    assign sts.done = hit | miss;
    assign sts.hit  = hit;
    assign hit_idx  = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
            addr_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            pend_reg <= 1'b0;
            addr_reg <= '0;
        end
        else
        begin
            if (hit | miss)
            begin
                busy_reg <= 1'b0;
            end
            if (issue)
            begin
                addr_reg <= addr_reg + (AW+1)'(1);
            end
            pend_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        vbit_reg <= ent_valid;
        idx_reg  <= addr_reg[AW-1:0];
    end

endmodule

`default_nettype wire

>>> hdl/virq_enable_change_mapper.sv
// virq_enable_change_mapper
// input channel: in_valid / in_stall carry one request (func and its fields).
// the block takes one request at a time; in_stall is high while it works.
// output channel: out_valid / out_stall carry result items, last marks the
// final result of a request. a held output register lets the block finish
// its work while a result waits; it stops only when a new result is due.
// work per request, N = PHYS_IRQ_COUNT:
//   map entry write: a table write, no result
//   forward lookup: one table read, then the result
//   reverse lookup: a scan of up to N table entries, stopping at the first match
//   status update: bit steps from bit 31 down, plus a table scan per changed
//   bit, since each changed bit scans the map table through its single
//   registered read port with one compare unit
// reset (rst_n, asynchronous) clears all valid bits of the map table at once
// and zeroes the saved enable words; no clearing pass is needed.
// while out_stall is high the pending result holds and the sequencer waits
// before emitting the next one.
`default_nettype none

module virq_enable_change_mapper import virq_pkg::*; #(
    parameter int PHYS_IRQ_COUNT = 256,
    parameter int VIRQ_COUNT     = 128
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [FUNC_W-1:0]     func,
    input  wire logic [PIRQ_W-1:0]     phys_irq,
    input  wire logic [GUEST_W-1:0]    guest_id,
    input  wire logic [VIRQ_W-1:0]     virt_irq,
    input  wire logic                  entry_valid,
    input  wire logic [WORD_IDX_W-1:0] word_index,
    input  wire logic [WORD_W-1:0]     enable_word,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [KIND_W-1:0]     kind,
    output logic      [PIRQ_W-1:0]     out_phys_irq,
    output logic      [GUEST_W-1:0]    out_guest_id,
    output logic      [VIRQ_W-1:0]     out_virt_irq,
    output logic                       found,
    output logic                       last
);

    localparam int AW         = $clog2(PHYS_IRQ_COUNT);
    localparam int WORD_COUNT = VIRQ_COUNT / WORD_W;
    localparam int WIW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_WRITE   = 3'd1;
    localparam logic [2:0] S_BIT     = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_FWD_RD  = 3'd4;
    localparam logic [2:0] S_FWD_CAP = 3'd5;
    localparam logic [2:0] S_EMIT    = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [FUNC_W-1:0]     func_reg;
    logic [PIRQ_W-1:0]     pirq_reg;
    logic                  pirq_ok_reg;
    logic [GUEST_W-1:0]    guest_reg;
    logic [VIRQ_W-1:0]     virq_reg;
    logic                  evalid_reg;
    logic [WORD_IDX_W-1:0] widx_reg;
    logic [WORD_W-1:0]     word_reg;
    logic [WORD_W-1:0]     changed_reg, changed_next;
    logic [BIT_W-1:0]      bit_reg, bit_next;
    logic                  fwd_vbit_reg;
    logic                  res_found_reg, res_found_next;
    logic [PIRQ_W-1:0]     res_pirq_reg, res_pirq_next;
    logic [GUEST_W-1:0]    res_guest_reg, res_guest_next;
    logic [VIRQ_W-1:0]     res_virq_reg, res_virq_next;

    logic [PHYS_IRQ_COUNT-1:0] valid_bits_reg;
    logic [WORD_W-1:0]         saved_reg [WORD_COUNT];

    logic                  out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [PIRQ_W-1:0]     opirq_reg, opirq_next;
    logic [GUEST_W-1:0]    oguest_reg, oguest_next;
    logic [VIRQ_W-1:0]     ovirq_reg, ovirq_next;
    logic                  ofound_reg, ofound_next;
    logic                  olast_reg, olast_next;

    logic                  in_acc;
    logic                  in_pirq_ok;
    logic                  in_widx_ok;
    logic                  out_free;
    logic                  load;
    logic                  save_en;
    logic                  scan_start;
    logic [VIRQ_W-1:0]     key_virq;
    logic [WORD_W-1:0]     rem_changed;

    logic [AW-1:0]         ram_addr;
    logic                  ram_we;
    logic                  ram_re;
    entry_t                ram_wdata;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t                rd_entry;
    logic                  ent_valid;

    logic [AW-1:0]         scan_addr;
    logic                  scan_re;
    scan_sts_t             scan_sts;
    logic [AW-1:0]         scan_idx;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_acc     = in_valid & ~in_stall;
    assign in_pirq_ok = (32'(phys_irq) < 32'(PHYS_IRQ_COUNT));
    assign in_widx_ok = (32'(word_index) < 32'(WORD_COUNT));
    assign out_free   = ~out_valid_reg | ~out_stall;
    assign key_virq   = (func_reg == FUNC_UPD) ? {widx_reg, bit_reg} : virq_reg;
    assign rem_changed = changed_reg & ~(WORD_W'(1) << bit_reg);

    // table port: scan addresses while scanning, else the request's index
    assign ram_addr  = (state_reg == S_SCAN) ? scan_addr : AW'(pirq_reg);
    assign ram_we    = (state_reg == S_WRITE) & pirq_ok_reg;
    assign ram_re    = (state_reg == S_FWD_RD) | scan_re;
    assign ram_wdata = evalid_reg ? entry_t'({guest_reg, virq_reg}) : entry_t'('0);
    assign rd_entry  = entry_t'(ram_rdata);
    assign ent_valid = valid_bits_reg[ram_addr];

    virq_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(PHYS_IRQ_COUNT)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    virq_scan_unit #(
        .PHYS_IRQ_COUNT(PHYS_IRQ_COUNT)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .key_guest (guest_reg),
        .key_virq  (key_virq),
        .ent_valid (ent_valid),
        .rd_entry  (rd_entry),
        .rd_addr   (scan_addr),
        .rd_en     (scan_re),
        .sts       (scan_sts),
        .hit_idx   (scan_idx)
    );

    always_comb
    begin
        state_next     = state_reg;
        changed_next   = changed_reg;
        bit_next       = bit_reg;
        res_found_next = res_found_reg;
        res_pirq_next  = res_pirq_reg;
        res_guest_next = res_guest_reg;
        res_virq_next  = res_virq_reg;
        scan_start     = 1'b0;
        save_en        = 1'b0;
        load           = 1'b0;
        kind_next      = kind_reg;
        opirq_next     = opirq_reg;
        oguest_next    = oguest_reg;
        ovirq_next     = ovirq_reg;
        ofound_next    = ofound_reg;
        olast_next     = olast_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    bit_next     = BIT_W'(WORD_W - 1);
                    changed_next = saved_reg[WIW'(word_index)] ^ enable_word;
                    case (func)
                        FUNC_WRITE: state_next = S_WRITE;
                        FUNC_UPD:   state_next = in_widx_ok ? S_BIT : S_IDLE;
                        FUNC_FWD:   state_next = S_FWD_RD;
                        FUNC_REV:
                        begin
                            state_next = S_SCAN;
                            scan_start = 1'b1;
                        end
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_WRITE:
            begin
                state_next = S_IDLE;
            end
            S_BIT:
            begin
                if (changed_reg == '0)
                begin
                    save_en    = 1'b1;
                    state_next = S_IDLE;
                end
                else if (changed_reg[bit_reg])
                begin
                    scan_start = 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    bit_next = bit_reg - BIT_W'(1);
                end
            end
            S_SCAN:
            begin
                if (scan_sts.done)
                begin
                    res_found_next = scan_sts.hit;
                    res_pirq_next  = scan_sts.hit ? PIRQ_W'(scan_idx) : '0;
                    state_next     = S_EMIT;
                end
            end
            S_FWD_RD:
            begin
                state_next = S_FWD_CAP;
            end
            S_FWD_CAP:
            begin
                res_found_next = fwd_vbit_reg;
                res_guest_next = fwd_vbit_reg ? rd_entry.guest : '0;
                res_virq_next  = fwd_vbit_reg ? rd_entry.virq : '0;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    ofound_next = res_found_reg;
                    case (func_reg)
                        FUNC_UPD:
                        begin
                            kind_next    = !res_found_reg ? KIND_UNMAP :
                                           (word_reg[bit_reg] ? KIND_EN : KIND_DIS);
                            opirq_next   = res_pirq_reg;
                            oguest_next  = guest_reg;
                            ovirq_next   = key_virq;
                            olast_next   = (rem_changed == '0);
                            changed_next = rem_changed;
                            if (rem_changed == '0)
                            begin
                                save_en    = 1'b1;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                bit_next   = bit_reg - BIT_W'(1);
                                state_next = S_BIT;
                            end
                        end
                        FUNC_FWD:
                        begin
                            kind_next   = KIND_FWD;
                            opirq_next  = pirq_reg;
                            oguest_next = res_guest_reg;
                            ovirq_next  = res_virq_reg;
                            olast_next  = 1'b1;
                            state_next  = S_IDLE;
                        end
                        default:
                        begin
                            kind_next   = KIND_REV;
                            opirq_next  = res_pirq_reg;
                            oguest_next = guest_reg;
                            ovirq_next  = virq_reg;
                            olast_next  = 1'b1;
                            state_next  = S_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = load | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            valid_bits_reg <= '0;
            for (int i = 0; i < WORD_COUNT; i++)
            begin
                saved_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (ram_we)
            begin
                valid_bits_reg[ram_addr] <= evalid_reg;
            end
            if (save_en)
            begin
                saved_reg[WIW'(widx_reg)] <= word_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            func_reg    <= func;
            pirq_reg    <= phys_irq;
            pirq_ok_reg <= in_pirq_ok;
            guest_reg   <= guest_id;
            virq_reg    <= virt_irq;
            evalid_reg  <= entry_valid;
            widx_reg    <= word_index;
            word_reg    <= enable_word;
        end
        changed_reg   <= changed_next;
        bit_reg       <= bit_next;
        fwd_vbit_reg  <= pirq_ok_reg & ent_valid;
        res_found_reg <= res_found_next;
        res_pirq_reg  <= res_pirq_next;
        res_guest_reg <= res_guest_next;
        res_virq_reg  <= res_virq_next;
        kind_reg      <= kind_next;
        opirq_reg     <= opirq_next;
        oguest_reg    <= oguest_next;
        ovirq_reg     <= ovirq_next;
        ofound_reg    <= ofound_next;
        olast_reg     <= olast_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign out_phys_irq = opirq_reg;
    assign out_guest_id = oguest_reg;
    assign out_virt_irq = ovirq_reg;
    assign found        = ofound_reg;
    assign last         = olast_reg;

endmodule

`default_nettype wire

>>> hdl/virq_checker.sv
`default_nettype none
`include "virq_enable_change_mapper_macros.svh"

module virq_checker import virq_pkg::*; (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [KIND_W-1:0]     kind,
    input wire logic [PIRQ_W-1:0]     out_phys_irq,
    input wire logic                  found,
    input wire logic                  last
);

    // a taken request keeps the block busy for at least the next cycle
    `VIRQ_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)

    // a stalled result holds
    `VIRQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(kind) && $stable(out_phys_irq) && $stable(last))

    // enable and disable commands always come from a mapped entry
    `VIRQ_ASSERT_SAME(a_cmd_found, out_valid && (kind == KIND_EN || kind == KIND_DIS), found)

    // unmapped notices carry no physical irq
    `VIRQ_ASSERT_SAME(a_unmap_clean, out_valid && kind == KIND_UNMAP,
        !found && out_phys_irq == '0)

    // lookups give exactly one result
    `VIRQ_ASSERT_SAME(a_lookup_last, out_valid && (kind == KIND_FWD || kind == KIND_REV), last)

endmodule

bind virq_enable_change_mapper virq_checker u_virq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .out_phys_irq (out_phys_irq),
    .found        (found),
    .last         (last)
);

`default_nettype wire

>>> sim/virq_enable_change_mapper_tb.sv
`timescale 1ns / 1ps

module virq_enable_change_mapper_tb;
    import virq_pkg::*;

    localparam int PIRQ_COUNT  = 256;
    localparam int WORD_COUNT  = 4;
    localparam int STUCK_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 600;
    localparam int ROW_COUNT   = 24;
    localparam int PHASE_ITEMS = 115;

    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [PIRQ_W-1:0]     pirq;
        logic [GUEST_W-1:0]    guest;
        logic [VIRQ_W-1:0]     virq;
        logic                  ev;
        logic [WORD_IDX_W-1:0] widx;
        logic [WORD_W-1:0]     word;
    } irq_req_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [PIRQ_W-1:0]  pirq;
        logic [GUEST_W-1:0] guest;
        logic [VIRQ_W-1:0]  virq;
        logic               found;
        logic               last;
    } irq_result_t;

    typedef struct packed {
        irq_req_t    req;
        logic        typed;
        irq_result_t res;
    } stim_row_t;

    localparam irq_result_t NO_RES = '0;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [FUNC_W-1:0]     func;
    logic [PIRQ_W-1:0]     phys_irq;
    logic [GUEST_W-1:0]    guest_id;
    logic [VIRQ_W-1:0]     virt_irq;
    logic                  entry_valid;
    logic [WORD_IDX_W-1:0] word_index;
    logic [WORD_W-1:0]     enable_word;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [KIND_W-1:0]     kind;
    logic [PIRQ_W-1:0]     out_phys_irq;
    logic [GUEST_W-1:0]    out_guest_id;
    logic [VIRQ_W-1:0]     out_virt_irq;
    logic                  found;
    logic                  last;

    logic               map_valid [PIRQ_COUNT];
    logic [GUEST_W-1:0] map_guest [PIRQ_COUNT];
    logic [VIRQ_W-1:0]  map_virq  [PIRQ_COUNT];
    logic [WORD_W-1:0]  saved_words [WORD_COUNT];

    irq_result_t expected_results [$];
    irq_result_t want_res;
    logic        cur_typed = 1'b0;
    irq_result_t cur_res = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int req_count = 0;
    int result_count = 0;
    int en_count = 0;
    int dis_count = 0;
    int unmap_count = 0;
    int lookup_count = 0;
    int stuck_cycles = 0;

    stim_row_t dir_rows [ROW_COUNT] = '{
        '{'{FUNC_FWD, 8'd0, 3'd0, 7'd0, 1'b0, 2'd0, 32'h0},
          1'b1, '{KIND_FWD, 8'd0, 3'd0, 7'd0, 1'b0, 1'b1}},
        '{'{FUNC_FWD, 8'd255, 3'd0, 7'd0, 1'b0, 2'd0, 32'h0},
          1'b1, '{KIND_FWD, 8'd255, 3'd0, 7'd0, 1'b0, 1'b1}},
        '{'{FUNC_REV, 8'd0, 3'd7, 7'd127, 1'b0, 2'd0, 32'h0},
          1'b1, '{KIND_REV, 8'd0, 3'd7, 7'd127, 1'b0, 1'b1}},
        '{'{FUNC_UPD, 8'd0, 3'd0, 7'd0, 1'b0, 2'd0, 32'h0}, 1'b0, NO_RES},
        '{'{FUNC_WRITE, 8'd255, 3'd7, 7'd127, 1'b1, 2'd0, 32'h0}, 1'b0, NO_RES},
        '{'{FUNC_FWD, 8'd255, 3'd0, 7'd0, 1'b0, 2'd0, 32'h0},
          1'b1, '{KIND_FWD, 8'd255, 3'd7, 7'd127, 1'b1, 1'b1}},
        '{'{FUNC_REV, 8'd0, 3'd7, 7'd127, 1'b0, 2'd0, 32'h0},
          1'b1, '{KIND_REV, 8'd255, 3'd7, 7'd127, 1'b1, 1'b1}},
        '{'{FUNC_WRITE, 8'd0, 3'd7, 7'd127, 1'b1, 2'd0, 32'h0}, 1'b0, NO_RES},
        '{'{FUNC_REV, 8'd0, 3'd7, 7'd127, 1'b0, 2'd0, 32'h0},
          1'b1, '{KIND_REV, 8'd0, 3'd7, 7'd127, 1'b1, 1'b1}},
        '{'{FUNC_WRITE, 8'd3, 3'd0, 7'd0, 1'b1, 2'd0, 32'h0}, 1'b0, NO_RES},
        '{'{FUNC_UPD, 8'd0, 3'd0, 7'd0, 1'b0, 2'd0, 32'h1}, 1'b0, NO_RES},
        '{'{FUNC_UPD, 8'd0, 3'd7, 7'd0, 1'b0, 2'd3, 32'hFFFF_FFFF}, 1'b0, NO_RES},
        '{'{FUNC_UPD, 8'd0, 3'd7, 7'd0, 1'b0, 2'd3, 32'h0}, 1'b0, NO_RES},
        '{'{FUNC_UPD, 8'd0, 3'd0, 7'd0, 1'b0, 2'd0, 32'h1}, 1'b0, NO_RES},
        '{'{FUNC_WRITE, 8'd0, 3'd5, 7'd9, 1'b0, 2'd0, 32'h0}, 1'b0, NO_RES},
        '{'{FUNC_FWD, 8'd0, 3'd0, 7'd0, 1'b0, 2'd0, 32'h0},
          1'b1, '{KIND_FWD, 8'd0, 3'd0, 7'd0, 1'b0, 1'b1}},
        '{'{FUNC_REV, 8'd0, 3'd7, 7'd127, 1'b0, 2'd0, 32'h0},
          1'b1, '{KIND_REV, 8'd255, 3'd7, 7'd127, 1'b1, 1'b1}},
        '{'{FUNC_UPD, 8'd0, 3'd3, 7'd0, 1'b0, 2'd1, 32'hAAAA_5555}, 1'b0, NO_RES},
        '{'{FUNC_UPD, 8'd0, 3'd3, 7'd0, 1'b0, 2'd1, 32'h5555_AAAA}, 1'b0, NO_RES},
        '{'{FUNC_UPD, 8'd0, 3'd0, 7'd0, 1'b0, 2'd2, 32'h8000_0000}, 1'b0, NO_RES},
        '{'{FUNC_UPD, 8'd0, 3'd0, 7'd0, 1'b0, 2'd0, 32'h0}, 1'b0, NO_RES},
        '{'{FUNC_FWD, 8'd3, 3'd0, 7'd0, 1'b0, 2'd0, 32'h0},
          1'b1, '{KIND_FWD, 8'd3, 3'd0, 7'd0, 1'b1, 1'b1}},
        '{'{FUNC_WRITE, 8'd255, 3'd0, 7'd0, 1'b0, 2'd0, 32'h0}, 1'b0, NO_RES},
        '{'{FUNC_UPD, 8'd0, 3'd7, 7'd0, 1'b0, 2'd3, 32'h8000_0000}, 1'b0, NO_RES}
    };

    virq_enable_change_mapper u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .phys_irq     (phys_irq),
        .guest_id     (guest_id),
        .virt_irq     (virt_irq),
        .entry_valid  (entry_valid),
        .word_index   (word_index),
        .enable_word  (enable_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .out_phys_irq (out_phys_irq),
        .out_guest_id (out_guest_id),
        .out_virt_irq (out_virt_irq),
        .found        (found),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int lowest_pirq(input logic [GUEST_W-1:0] g,
                                       input logic [VIRQ_W-1:0] v);
        for (int i = 0; i < PIRQ_COUNT; i++)
        begin
            if (map_valid[i] && map_guest[i] == g && map_virq[i] == v)
                return i;
        end
        return -1;
    endfunction

    // first mapped entry from a random start, wrapping round, -1 if the table is empty
    function automatic int pick_mapped();
        int start;
        int idx;
        start = $urandom_range(PIRQ_COUNT - 1);
        for (int i = 0; i < PIRQ_COUNT; i++)
        begin
            idx = (start + i) % PIRQ_COUNT;
            if (map_valid[idx])
                return idx;
        end
        return -1;
    endfunction

    task automatic compute_irq_results(input irq_req_t r);
        irq_result_t res;
        logic [WORD_W-1:0] changed;
        logic [VIRQ_W-1:0] v;
        int p;
        int left;
        case (r.func)
            FUNC_WRITE:
            begin
                map_valid[r.pirq] = r.ev;
                map_guest[r.pirq] = r.ev ? r.guest : '0;
                map_virq[r.pirq]  = r.ev ? r.virq : '0;
            end
            FUNC_UPD:
            begin
                changed = saved_words[r.widx] ^ r.word;
                left = $countones(changed);
                for (int b = WORD_W - 1; b >= 0; b--)
                begin
                    if (changed[b])
                    begin
                        left--;
                        v = VIRQ_W'(int'(r.widx) * WORD_W + b);
                        p = lowest_pirq(r.guest, v);
                        if (p < 0)
                            res.kind = KIND_UNMAP;
                        else
                            res.kind = r.word[b] ? KIND_EN : KIND_DIS;
                        res.pirq  = (p < 0) ? '0 : PIRQ_W'(p);
                        res.guest = r.guest;
                        res.virq  = v;
                        res.found = (p >= 0);
                        res.last  = (left == 0);
                        expected_results.push_back(res);
                    end
                end
                saved_words[r.widx] = r.word;
            end
            FUNC_FWD:
            begin
                res.kind  = KIND_FWD;
                res.pirq  = r.pirq;
                res.guest = map_valid[r.pirq] ? map_guest[r.pirq] : '0;
                res.virq  = map_valid[r.pirq] ? map_virq[r.pirq] : '0;
                res.found = map_valid[r.pirq];
                res.last  = 1'b1;
                expected_results.push_back(res);
            end
            default:
            begin
                p = lowest_pirq(r.guest, r.virq);
                res.kind  = KIND_REV;
                res.pirq  = (p < 0) ? '0 : PIRQ_W'(p);
                res.guest = r.guest;
                res.virq  = r.virq;
                res.found = (p >= 0);
                res.last  = 1'b1;
                expected_results.push_back(res);
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("tb: mismatch on %s: got %0d, expected %0d at %0t",
                 what, got, want, $time);
        mismatch_count++;
    endtask

    // mostly well-formed traffic aimed at mapped entries, the rest noise
    task automatic make_random_req(output irq_req_t r);
        int sel;
        int k;
        int p;
        logic [63:0] rnd;
        rnd = {$urandom(), $urandom()};
        r = rnd[$bits(irq_req_t)-1:0];
        sel = $urandom_range(99);
        p = pick_mapped();
        if (sel < 30)
        begin
            r.func = FUNC_WRITE;
            r.ev = ($urandom_range(9) < 8);
            if (p >= 0 && $urandom_range(3) == 0)
            begin
                r.guest = map_guest[p];
                r.virq  = map_virq[p];
            end
        end
        else if (sel < 65)
        begin
            r.func = FUNC_UPD;
            k = $urandom_range(99);
            if (p >= 0 && k < 70)
            begin
                r.guest = map_guest[p];
                r.widx  = map_virq[p][VIRQ_W-1:BIT_W];
                r.word  = saved_words[r.widx] ^ (32'd1 << map_virq[p][BIT_W-1:0]);
                if ($urandom_range(1) == 1)
                    r.word = r.word ^ (32'd1 << $urandom_range(WORD_W - 1));
            end
            else if (k < 80)
                r.word = $urandom();
            else if (k < 83)
                r.word = ~saved_words[r.widx];
            else if (k < 90)
                r.word = saved_words[r.widx];
            else
                r.word = saved_words[r.widx] ^ (32'd1 << $urandom_range(WORD_W - 1))
                         ^ (32'd1 << $urandom_range(WORD_W - 1));
        end
        else if (sel < 85)
        begin
            r.func = FUNC_FWD;
            if (p >= 0 && $urandom_range(9) < 6)
                r.pirq = PIRQ_W'(p);
        end
        else
        begin
            r.func = FUNC_REV;
            if (p >= 0 && $urandom_range(9) < 6)
            begin
                r.guest = map_guest[p];
                r.virq  = map_virq[p];
            end
        end
    endtask

    task automatic send_request(input irq_req_t r, input logic typed,
                                input irq_result_t res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        func        <= r.func;
        phys_irq    <= r.pirq;
        guest_id    <= r.guest;
        virt_irq    <= r.virq;
        entry_valid <= r.ev;
        word_index  <= r.widx;
        enable_word <= r.word;
        cur_typed = typed;
        cur_res   = res;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!(in_valid && !in_stall))
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result, kind", kind, 0);
                else
                begin
                    want_res = expected_results.pop_front();
                    if (kind !== want_res.kind)
                        report_mismatch("kind", kind, want_res.kind);
                    if (out_phys_irq !== want_res.pirq)
                        report_mismatch("out_phys_irq", out_phys_irq, want_res.pirq);
                    if (out_guest_id !== want_res.guest)
                        report_mismatch("out_guest_id", out_guest_id, want_res.guest);
                    if (out_virt_irq !== want_res.virq)
                        report_mismatch("out_virt_irq", out_virt_irq, want_res.virq);
                    if (found !== want_res.found)
                        report_mismatch("found", found, want_res.found);
                    if (last !== want_res.last)
                        report_mismatch("last", last, want_res.last);
                    result_count++;
                    case (want_res.kind)
                        KIND_EN:    en_count++;
                        KIND_DIS:   dis_count++;
                        KIND_UNMAP: unmap_count++;
                        default:    lookup_count++;
                    endcase
                end
            end
            if (in_valid && !in_stall)
            begin
                if (cur_typed)
                    expected_results.push_back(cur_res);
                else
                    compute_irq_results({func, phys_irq, guest_id, virt_irq,
                                         entry_valid, word_index, enable_word});
                req_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("tb: no handshake for %0d cycles, %0d results outstanding",
                     STUCK_LIMIT, expected_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : stimulus
        irq_req_t r;
        int phase;
        for (int i = 0; i < PIRQ_COUNT; i++)
        begin
            map_valid[i] = 1'b0;
            map_guest[i] = '0;
            map_virq[i]  = '0;
        end
        for (int i = 0; i < WORD_COUNT; i++)
            saved_words[i] = '0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        func        = FUNC_WRITE;
        phys_irq    = '0;
        guest_id    = '0;
        virt_irq    = '0;
        entry_valid = 1'b0;
        word_index  = '0;
        enable_word = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 23;
        recv_idle_pct = 71;
        for (int i = 0; i < ROW_COUNT; i++)
            send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 71 : 0;
            recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 23 : 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                make_random_req(r);
                send_request(r, 1'b0, NO_RES);
            end
        end
        in_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d requests (%0d directed), %0d results checked",
                 req_count, ROW_COUNT, result_count);
        $display("tb: %0d enable, %0d disable, %0d unmapped, %0d lookup results",
                 en_count, dis_count, unmap_count, lookup_count);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
